### rtl/cpi_pkg.sv
// Shared types, constants and helpers for the complex power integrator.
package cpi_pkg;

  // Default depth of the accumulator memory (channels)
  localparam int unsigned MAX_CHANNELS_DEF = 1024;

  // Field widths fixed by the interface
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned POWER_W    = 8;   // re^2 + im^2 fits in 0..128
  localparam int unsigned SQUARE_W   = 7;   // one square fits in 0..64
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned CH_CFG_W   = 11;
  localparam int unsigned FR_CFG_W   = 17;
  localparam int unsigned FR_POS_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned OUT_TDATA_W = 40; // 10 + 24 bits, padded to bytes

  // Frame count limits
  localparam logic [FR_CFG_W-1:0] MAX_FRAMES = 17'd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_TO_INTEGRATE = 2'd1;

  // Register reset values
  localparam logic [CH_CFG_W-1:0] CHANNEL_COUNT_RST = 11'd1024;
  localparam logic [FR_CFG_W-1:0] FRAMES_RST        = 17'd1;

  // Result queue depth and pointer width
  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 2;

  // Per-item control flags passed from the sequencer to the accumulate stage
  typedef struct packed {
    logic first_frame;  // overwrite the accumulator
    logic emit;         // last frame: deliver the total
    logic last_channel; // final channel of the integration output
  } item_flags_t;

  // One result held in the output queue
  typedef struct packed {
    logic                last_channel;
    logic [SUM_W-1:0]    power_sum;
    logic [INDEX_W-1:0]  channel_index;
  } result_t;

  // Square of an offset-8 nibble: flipping the top bit gives two's complement
  function automatic logic [SQUARE_W-1:0] nibble_square(input logic [NIBBLE_W-1:0] nib);
    logic signed [NIBBLE_W-1:0] v;
    logic signed [2*NIBBLE_W-1:0] sq;
    v  = signed'(nib ^ 4'b1000);
    sq = v * v;
    return sq[SQUARE_W-1:0];
  endfunction

endpackage

### rtl/cpi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpi_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cpi_sequencer.sv
// Configuration registers and channel/frame position tracking.
module cpi_sequencer #(
  parameter int unsigned MAX_CHANNELS = cpi_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_accept,
  input  logic [cpi_pkg::SAMPLE_W-1:0]        sample,
  output logic [$clog2(MAX_CHANNELS)-1:0]     item_ch,
  output logic [cpi_pkg::POWER_W-1:0]         item_power,
  output cpi_pkg::item_flags_t                item_flags
);

  localparam int unsigned CH_W  = $clog2(MAX_CHANNELS);
  localparam int unsigned CNT_W = CH_W + 1;

  logic [cpi_pkg::CH_CFG_W-1:0] channel_count_r;
  logic [cpi_pkg::FR_CFG_W-1:0] frames_r;
  logic [CH_W-1:0]              ch_pos_r,  ch_pos_nxt;
  logic [cpi_pkg::FR_POS_W-1:0] fr_pos_r,  fr_pos_nxt;

  logic [CNT_W-1:0]             n_eff;
  logic [cpi_pkg::FR_CFG_W-1:0] f_eff;
  logic [CNT_W-1:0]             ch_inc;
  logic [cpi_pkg::FR_CFG_W-1:0] fr_inc;
  logic                         wrap;
  logic                         cfg_hit;

  // Clamp the configured counts into their working ranges
  always_comb begin
    if (channel_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(channel_count_r) > 32'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = CNT_W'(channel_count_r);
    end

    if (frames_r == '0) begin
      f_eff = cpi_pkg::FR_CFG_W'(1);
    end else if (frames_r > cpi_pkg::MAX_FRAMES) begin
      f_eff = cpi_pkg::MAX_FRAMES;
    end else begin
      f_eff = frames_r;
    end
  end

  always_comb begin
    ch_inc = {1'b0, ch_pos_r} + CNT_W'(1);
    fr_inc = {1'b0, fr_pos_r} + cpi_pkg::FR_CFG_W'(1);
    wrap   = (ch_inc >= n_eff);

    item_ch                 = ch_pos_r;
    item_power              = cpi_pkg::POWER_W'(cpi_pkg::nibble_square(sample[7:4]))
                            + cpi_pkg::POWER_W'(cpi_pkg::nibble_square(sample[3:0]));
    item_flags.first_frame  = (fr_pos_r == '0);
    item_flags.emit         = (fr_inc >= f_eff);
    item_flags.last_channel = (ch_inc == n_eff);

    ch_pos_nxt = ch_pos_r;
    fr_pos_nxt = fr_pos_r;
    if (in_accept) begin
      if (wrap) begin
        ch_pos_nxt = '0;
        fr_pos_nxt = (fr_inc >= f_eff) ? '0 : fr_inc[cpi_pkg::FR_POS_W-1:0];
      end else begin
        ch_pos_nxt = ch_inc[CH_W-1:0];
      end
    end

    cfg_hit = cfg_we && ((cfg_index == cpi_pkg::REG_CHANNEL_COUNT) ||
                         (cfg_index == cpi_pkg::REG_FRAMES_TO_INTEGRATE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= cpi_pkg::CHANNEL_COUNT_RST;
      frames_r        <= cpi_pkg::FRAMES_RST;
      ch_pos_r        <= '0;
      fr_pos_r        <= '0;
    end else begin
      if (cfg_we && (cfg_index == cpi_pkg::REG_CHANNEL_COUNT)) begin
        channel_count_r <= cfg_data[cpi_pkg::CH_CFG_W-1:0];
      end
      if (cfg_we && (cfg_index == cpi_pkg::REG_FRAMES_TO_INTEGRATE)) begin
        frames_r <= cfg_data[cpi_pkg::FR_CFG_W-1:0];
      end
      // Restart the integration on any register write
      if (cfg_hit) begin
        ch_pos_r <= '0;
        fr_pos_r <= '0;
      end else begin
        ch_pos_r <= ch_pos_nxt;
        fr_pos_r <= fr_pos_nxt;
      end
    end
  end

endmodule

### rtl/cpi_out_fifo.sv
// Three-entry result queue between the accumulate stage and the output channel.
module cpi_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  cpi_pkg::result_t              push_data,
  input  logic                          pop,
  output logic                          not_empty,
  output cpi_pkg::result_t              head,
  output logic [cpi_pkg::OUT_CNT_W-1:0] count
);

  cpi_pkg::result_t                 entries_r [cpi_pkg::OUT_DEPTH];
  logic [cpi_pkg::OUT_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cpi_pkg::OUT_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cpi_pkg::OUT_CNT_W-1:0]    count_r,  count_nxt;
  logic                             do_pop;

  localparam logic [cpi_pkg::OUT_PTR_W-1:0] LAST_PTR =
    cpi_pkg::OUT_PTR_W'(cpi_pkg::OUT_DEPTH - 1);

  always_comb begin
    do_pop     = pop && (count_r != '0);
    wr_ptr_nxt = push   ? ((wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ((rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + cpi_pkg::OUT_CNT_W'(push) - cpi_pkg::OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];
  assign count     = count_r;

endmodule

### rtl/complex_power_integrator_top.sv
// Top level of the complex power integrator: sequencer, accumulator RAM stage, result queue.
//
// Each input transaction carries one byte, high nibble real and low nibble imaginary, both
// offset-8 encoded. The block squares and sums the two parts and accumulates that power
// per frequency channel in a 24-bit accumulator memory of MAX_CHANNELS entries. Samples
// arrive in channel order, frame after frame; the first frame of an integration overwrites
// each accumulator, later frames add to it, and during the last of frames_to_integrate
// frames every sample yields one output transaction with the channel index, its total and
// tlast on the final channel. Other frames yield no output. One sample is taken per clock
// while in_tready is high: the accumulator RAM is read as a sample is accepted and written
// back in the next cycle, a one-entry bypass covers a read of the channel written in that
// same cycle (a single-channel frame), and a three-entry result queue lets input run on
// while a result waits. A result is registered in the accumulate stage, then in the result
// queue, before it is offered. in_tready drops only when the result queue, counting the
// sample in flight, is full. Writing either register restarts the integration at channel
// zero of the first frame; write it only while idle. No clearing pass is needed after reset.
module complex_power_integrator_top #(
  parameter int unsigned MAX_CHANNELS = cpi_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpi_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Sample stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cpi_pkg::SAMPLE_W-1:0]      in_tdata,   // [7:0] sample_byte
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cpi_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] channel_index, [33:10] power_sum
  output logic                              out_tlast   // last_channel
);

  localparam int unsigned CH_W = $clog2(MAX_CHANNELS);

  logic                         in_accept;
  logic [CH_W-1:0]              item_ch;
  logic [cpi_pkg::POWER_W-1:0]  item_power;
  cpi_pkg::item_flags_t         item_flags;

  // Accumulate stage
  logic                         s1_valid_r;
  logic [CH_W-1:0]              s1_ch_r;
  logic [cpi_pkg::POWER_W-1:0]  s1_power_r;
  cpi_pkg::item_flags_t         s1_flags_r;

  // Bypass of the write made in the cycle the current read was issued
  logic                         fwd_valid_r;
  logic [CH_W-1:0]              fwd_addr_r;
  logic [cpi_pkg::SUM_W-1:0]    fwd_data_r;

  logic [cpi_pkg::SUM_W-1:0]    rd_data;
  logic [cpi_pkg::SUM_W-1:0]    acc_base;
  logic [cpi_pkg::SUM_W-1:0]    acc;
  logic [31:0]                  ch_ext;
  cpi_pkg::result_t             result;
  cpi_pkg::result_t             head;
  logic                         fifo_not_empty;
  logic [cpi_pkg::OUT_CNT_W-1:0] fifo_count;

  // Hold input off when the queue plus the sample in flight would fill it
  assign in_tready = (3'(fifo_count) + 3'(s1_valid_r)) < 3'(cpi_pkg::OUT_DEPTH);
  assign in_accept = in_tvalid && in_tready;

  cpi_sequencer #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .sample     (in_tdata),
    .item_ch    (item_ch),
    .item_power (item_power),
    .item_flags (item_flags)
  );

  cpi_ram #(
    .WIDTH (cpi_pkg::SUM_W),
    .DEPTH (MAX_CHANNELS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_ch_r),
    .wdata (acc),
    .re    (in_accept),
    .raddr (item_ch),
    .rdata (rd_data)
  );

  // Overwrite on the first frame, otherwise add to the stored total
  always_comb begin
    acc_base = (fwd_valid_r && (fwd_addr_r == s1_ch_r)) ? fwd_data_r : rd_data;
    if (s1_flags_r.first_frame) begin
      acc = cpi_pkg::SUM_W'(s1_power_r);
    end else begin
      acc = acc_base + cpi_pkg::SUM_W'(s1_power_r);
    end
    ch_ext               = 32'(s1_ch_r);
    result.channel_index = ch_ext[cpi_pkg::INDEX_W-1:0];
    result.power_sum     = acc;
    result.last_channel  = s1_flags_r.last_channel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_accept;
      // Bypass only when a write lands on the same edge as the next read
      fwd_valid_r <= s1_valid_r && in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ch_r    <= item_ch;
      s1_power_r <= item_power;
      s1_flags_r <= item_flags;
    end
    fwd_addr_r <= s1_ch_r;
    fwd_data_r <= acc;
  end

  cpi_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && s1_flags_r.emit),
    .push_data (result),
    .pop       (out_tready),
    .not_empty (fifo_not_empty),
    .head      (head),
    .count     (fifo_count)
  );

  assign out_tvalid = fifo_not_empty;
  assign out_tdata  = {6'd0, head.power_sum, head.channel_index};
  assign out_tlast  = head.last_channel;

endmodule
